### src/fbfla_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the fixed block free-list allocator.
// Depends on nothing; fbfla_ifs, fbfla_offset and the top take their names from here.
package fbfla_pkg;

  localparam int MAX_BLOCKS_DEF = 256;
  localparam int WORD_BYTES_DEF = 8;
  localparam int INDEX_SPAN     = 256;

  localparam int ACT_W      = 2;
  localparam int IDX_W      = 8;
  localparam int ST_W       = 2;
  localparam int OFF_W      = 20;
  localparam int CNT_W      = 9;
  localparam int NB_W       = 9;
  localparam int BB_W       = 13;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [NB_W-1:0]  NUM_BLOCKS_RST  = 9'd256;
  localparam logic [BB_W-1:0]  BLOCK_BYTES_RST = 13'd8;
  localparam logic [CNT_W-1:0] COUNT_MAX       = 9'h1FF;

  typedef enum logic [ACT_W-1:0] {
    ACT_INIT,
    ACT_ALLOC,
    ACT_FREE,
    ACT_NOP
  } action_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK,
    ST_EMPTY,
    ST_RANGE
  } status_t;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_ALLOC,
    S_EMIT
  } state_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_NUM_BLOCKS,
    CFG_BLOCK_BYTES
  } cfg_addr_t;

endpackage

### src/fbfla_ifs.sv
`timescale 1ns / 1ps
// Channel interfaces of the allocator: request, response and configuration.
// Depends on fbfla_pkg for the field widths.
interface fbfla_req_if;
  logic                         valid;
  logic                         ready;
  logic [fbfla_pkg::ACT_W-1:0]  action;
  logic [fbfla_pkg::IDX_W-1:0]  block_index;
  modport source (output valid, action, block_index, input ready);
  modport sink (input valid, action, block_index, output ready);
endinterface

interface fbfla_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [fbfla_pkg::ST_W-1:0]   status;
  logic [fbfla_pkg::IDX_W-1:0]  granted_index;
  logic [fbfla_pkg::OFF_W-1:0]  byte_offset;
  logic [fbfla_pkg::CNT_W-1:0]  free_count;
  modport source (output valid, status, granted_index, byte_offset, free_count, input ready);
  modport sink (input valid, status, granted_index, byte_offset, free_count, output ready);
endinterface

interface fbfla_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [fbfla_pkg::CFG_ADDR_W-1:0]  addr;
  logic [fbfla_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

### src/fbfla_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// Depends on nothing.
module fbfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### src/fbfla_offset.sv
`timescale 1ns / 1ps
// Byte offset of a granted block: word size plus index times the rounded block size.
// Depends on fbfla_pkg for widths.
module fbfla_offset #(
  parameter int WORD_BYTES = fbfla_pkg::WORD_BYTES_DEF
) (
  input  logic                        clk,
  input  logic [fbfla_pkg::BB_W-1:0]  block_bytes,
  input  logic [fbfla_pkg::IDX_W-1:0] granted,
  output logic [fbfla_pkg::OFF_W-1:0] offset
);

  localparam int SUM_W   = fbfla_pkg::BB_W + 1;
  localparam int SHIFT   = SUM_W + 4;
  localparam int RECIP   = ((1 << SHIFT) + WORD_BYTES - 1) / WORD_BYTES;
  localparam int PROD_W  = SUM_W + SHIFT + 1;
  localparam int MUL_W   = fbfla_pkg::IDX_W + SUM_W;

  logic [SUM_W-1:0]  bsum;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  quot;
  logic [SUM_W-1:0]  rnd;
  logic [MUL_W:0]    total;

  // Rounding up to the word uses a reciprocal multiply that is exact for this range.
  assign bsum = SUM_W'(block_bytes) + SUM_W'(WORD_BYTES - 1);
  assign prod = PROD_W'(bsum) * PROD_W'(RECIP);
  assign quot = prod[SHIFT +: SUM_W];

  always_ff @(posedge clk) begin
    rnd <= SUM_W'(quot * SUM_W'(WORD_BYTES));
  end

  assign total  = (MUL_W + 1)'(granted) * (MUL_W + 1)'(rnd) + (MUL_W + 1)'(WORD_BYTES);
  assign offset = total[fbfla_pkg::OFF_W-1:0];

endmodule

### src/fixed_block_free_list_allocator_top.sv
`timescale 1ns / 1ps
// Fixed block pool allocator with a LIFO free list held in a link RAM.
// Free, empty alloc, bad index and no-op: result registered into rsp, one beat a cycle while rsp is not stalled.
// Alloc: the beat moves to S_ALLOC while the link RAM reads the head; the result is then registered.
// Init: S_INIT writes one link per block into the link RAM, then the result is registered.
// After rst the same chain sweep runs over min(256, MAX_BLOCKS) entries with req.ready low.
// Depends on fbfla_pkg, fbfla_ifs, fbfla_ram and fbfla_offset.
module fixed_block_free_list_allocator_top #(
  parameter int MAX_BLOCKS = fbfla_pkg::MAX_BLOCKS_DEF,
  parameter int WORD_BYTES = fbfla_pkg::WORD_BYTES_DEF
) (
  input logic           clk,
  input logic           rst,
  fbfla_req_if.sink     req,
  fbfla_rsp_if.source   rsp,
  fbfla_cfg_if.sink     cfg
);

  localparam int DEPTH = (MAX_BLOCKS < fbfla_pkg::INDEX_SPAN) ? MAX_BLOCKS
                                                              : fbfla_pkg::INDEX_SPAN;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = fbfla_pkg::CNT_W;
  localparam int IW = fbfla_pkg::IDX_W;
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
  localparam logic [CW-1:0] POOL_RST = (fbfla_pkg::NUM_BLOCKS_RST > DEPTH_C) ? DEPTH_C
                                                                              : fbfla_pkg::NUM_BLOCKS_RST;

  fbfla_pkg::state_t state, state_next;

  logic [fbfla_pkg::NB_W-1:0] num_blocks;
  logic [fbfla_pkg::BB_W-1:0] block_bytes;
  logic [IW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] sweep, sweep_next;
  logic [CW-1:0] pool_n, pool_n_next;
  logic          init_emit, init_emit_next;

  logic [CW-1:0] pool_cur;
  logic [CW-1:0] sweep_inc;
  logic          req_fire;
  logic          out_free;

  logic                         fin;
  fbfla_pkg::status_t           fin_status;
  logic [IW-1:0]                fin_granted;
  logic [fbfla_pkg::OFF_W-1:0]  fin_offset;

  fbfla_pkg::status_t           res_status;
  logic [IW-1:0]                res_granted;
  logic [fbfla_pkg::OFF_W-1:0]  res_offset;
  logic [CW-1:0]                res_count;

  logic                         out_valid;
  fbfla_pkg::status_t           out_status;
  logic [IW-1:0]                out_granted;
  logic [fbfla_pkg::OFF_W-1:0]  out_offset;
  logic [CW-1:0]                out_count;

  logic                         mem_we;
  logic [AW-1:0]                mem_addr;
  logic [IW-1:0]                mem_wdata;
  logic [IW-1:0]                mem_rdata;
  logic [fbfla_pkg::OFF_W-1:0]  offset;

  fbfla_ram #(
    .WIDTH (IW),
    .DEPTH (DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  fbfla_offset #(
    .WORD_BYTES (WORD_BYTES)
  ) u_offset (
    .clk         (clk),
    .block_bytes (block_bytes),
    .granted     (head),
    .offset      (offset)
  );

  assign pool_cur  = (num_blocks > DEPTH_C) ? DEPTH_C : num_blocks;
  assign sweep_inc = sweep + CW'(1);
  assign req.ready = (state == fbfla_pkg::S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign cfg.ready = 1'b1;

  always_comb begin
    state_next     = state;
    head_next      = head;
    count_next     = count;
    sweep_next     = sweep;
    pool_n_next    = pool_n;
    init_emit_next = init_emit;
    fin            = 1'b0;
    fin_status     = fbfla_pkg::ST_OK;
    fin_granted    = '0;
    fin_offset     = '0;
    mem_we         = 1'b0;
    mem_addr       = head[AW-1:0];
    mem_wdata      = head;
    case (state)
      fbfla_pkg::S_INIT: begin
        if (sweep == pool_n) begin
          head_next  = '0;
          count_next = pool_n;
          if (init_emit) begin
            fin = 1'b1;
          end else begin
            state_next = fbfla_pkg::S_IDLE;
          end
        end else begin
          mem_we     = 1'b1;
          mem_addr   = sweep[AW-1:0];
          mem_wdata  = (sweep_inc < pool_n) ? sweep_inc[IW-1:0] : '0;
          sweep_next = sweep_inc;
        end
      end
      fbfla_pkg::S_IDLE: begin
        if (req_fire) begin
          case (fbfla_pkg::action_t'(req.action))
            fbfla_pkg::ACT_INIT: begin
              pool_n_next    = pool_cur;
              sweep_next     = '0;
              init_emit_next = 1'b1;
              state_next     = fbfla_pkg::S_INIT;
            end
            fbfla_pkg::ACT_ALLOC: begin
              if (count == '0) begin
                fin        = 1'b1;
                fin_status = fbfla_pkg::ST_EMPTY;
              end else begin
                state_next = fbfla_pkg::S_ALLOC;
              end
            end
            fbfla_pkg::ACT_FREE: begin
              fin = 1'b1;
              if (CW'(req.block_index) >= pool_cur) begin
                fin_status = fbfla_pkg::ST_RANGE;
              end else begin
                mem_we     = 1'b1;
                mem_addr   = req.block_index[AW-1:0];
                mem_wdata  = head;
                head_next  = req.block_index;
                count_next = (count == fbfla_pkg::COUNT_MAX) ? count : count + CW'(1);
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      fbfla_pkg::S_ALLOC: begin
        head_next   = mem_rdata;
        count_next  = count - CW'(1);
        fin         = 1'b1;
        fin_granted = head;
        fin_offset  = offset;
      end
      fbfla_pkg::S_EMIT: begin
        if (out_free) begin
          state_next = fbfla_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fbfla_pkg::S_IDLE;
      end
    endcase
    if (fin) begin
      state_next = out_free ? fbfla_pkg::S_IDLE : fbfla_pkg::S_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= fbfla_pkg::S_INIT;
      num_blocks  <= fbfla_pkg::NUM_BLOCKS_RST;
      block_bytes <= fbfla_pkg::BLOCK_BYTES_RST;
      head        <= '0;
      count       <= '0;
      sweep       <= '0;
      pool_n      <= POOL_RST;
      init_emit   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      sweep     <= sweep_next;
      pool_n    <= pool_n_next;
      init_emit <= init_emit_next;
      if (cfg.valid && cfg.ready) begin
        case (fbfla_pkg::cfg_addr_t'(cfg.addr))
          fbfla_pkg::CFG_NUM_BLOCKS:  num_blocks  <= cfg.data[fbfla_pkg::NB_W-1:0];
          fbfla_pkg::CFG_BLOCK_BYTES: block_bytes <= cfg.data;
          default: ;
        endcase
      end
      if ((fin || state == fbfla_pkg::S_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin && !out_free) begin
      res_status  <= fin_status;
      res_granted <= fin_granted;
      res_offset  <= fin_offset;
      res_count   <= count_next;
    end
    if (fin && out_free) begin
      out_status  <= fin_status;
      out_granted <= fin_granted;
      out_offset  <= fin_offset;
      out_count   <= count_next;
    end else if (state == fbfla_pkg::S_EMIT && out_free) begin
      out_status  <= res_status;
      out_granted <= res_granted;
      out_offset  <= res_offset;
      out_count   <= res_count;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.granted_index = out_granted;
  assign rsp.byte_offset   = out_offset;
  assign rsp.free_count    = out_count;

endmodule
